// ===== rtl/core/lspd_pkg.sv =====
// Package with shared types and constants of the laser serial packet decoder.
package lspd_pkg;

	// Field widths of the byte and result words.
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned EVENT_W = 3;
	localparam int unsigned DAC_W   = 16;
	localparam int unsigned LEVEL_W = 3;
	localparam int unsigned RATE_W  = 16;
	localparam int unsigned LED_W   = 16;

	// Configuration port geometry.
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned PADDR_W = 3;

	// Reset value of the LED period register and countdown.
	localparam logic [LED_W-1:0] LED_PERIOD_RST = 16'd500;

	// Event codes carried in event_res.
	localparam logic [EVENT_W-1:0] EV_POINT    = 3'd0;
	localparam logic [EVENT_W-1:0] EV_SET_RATE = 3'd1;
	localparam logic [EVENT_W-1:0] EV_RESET    = 3'd2;
	localparam logic [EVENT_W-1:0] EV_IDENTIFY = 3'd3;
	localparam logic [EVENT_W-1:0] EV_UNKNOWN  = 3'd4;

	// Command nibbles (high nibble of the command byte).
	localparam logic [3:0] CMD_POINT    = 4'h2;
	localparam logic [3:0] CMD_SET_RATE = 4'h1;
	localparam logic [3:0] CMD_RESET    = 4'hF;
	localparam logic [3:0] CMD_IDENTIFY = 4'hE;

	// Sync byte skipped in the command position.
	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

	// Channel prefixes of the two DAC words.
	localparam logic [3:0] DAC_A_PREFIX = 4'b0111;
	localparam logic [3:0] DAC_B_PREFIX = 4'b1111;

	// Register index of led_period.
	localparam logic REG_LED_PERIOD = 1'b0;

	// One decoded result word.
	typedef struct packed {
		logic [EVENT_W-1:0] event_res;
		logic [DAC_W-1:0]   dac_a_word;
		logic [DAC_W-1:0]   dac_b_word;
		logic [LEVEL_W-1:0] red_level;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] blue_level;
		logic [RATE_W-1:0]  point_rate;
		logic               status_led;
	} res_t;

endpackage

// ===== rtl/core/lspd_ifs.sv =====
// Valid/ready channel interfaces for received bytes and decoded results.
interface lspd_byte_if;
	logic                       valid;
	logic                       ready;
	logic [lspd_pkg::BYTE_W-1:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface lspd_res_if;
	logic                        valid;
	logic                        ready;
	logic [lspd_pkg::EVENT_W-1:0] event_res;
	logic [lspd_pkg::DAC_W-1:0]   dac_a_word;
	logic [lspd_pkg::DAC_W-1:0]   dac_b_word;
	logic [lspd_pkg::LEVEL_W-1:0] red_level;
	logic [lspd_pkg::LEVEL_W-1:0] green_level;
	logic [lspd_pkg::LEVEL_W-1:0] blue_level;
	logic [lspd_pkg::RATE_W-1:0]  point_rate;
	logic                         status_led;

	modport source(output valid, output event_res, output dac_a_word, output dac_b_word,
		output red_level, output green_level, output blue_level, output point_rate,
		output status_led, input ready);
	modport sink(input valid, input event_res, input dac_a_word, input dac_b_word,
		input red_level, input green_level, input blue_level, input point_rate,
		input status_led, output ready);
endinterface

// ===== rtl/core/lspd_cfg_regs.sv =====
// APB-style register block holding the status LED period.
module lspd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lspd_pkg::PADDR_W-1:0]   paddr,
	input  logic [lspd_pkg::PDATA_W-1:0]   pwdata,
	output logic [lspd_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output logic [lspd_pkg::LED_W-1:0]     led_period
);

	logic [lspd_pkg::LED_W-1:0] led_period_q;
	logic                       reg_hit;

	// Word index is the address above the byte offset.
	assign reg_hit = (paddr[lspd_pkg::PADDR_W-1] == lspd_pkg::REG_LED_PERIOD);
	assign pready  = 1'b1;

	// Register write in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_period_q <= lspd_pkg::LED_PERIOD_RST;
		end else if (psel && penable && pwrite && reg_hit) begin
			led_period_q <= pwdata[lspd_pkg::LED_W-1:0];
		end
	end

	// Read data; unmapped addresses read as zero.
	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata[lspd_pkg::LED_W-1:0] = led_period_q;
		end
	end

	assign led_period = led_period_q;

endmodule

// ===== rtl/core/lspd_framer.sv =====
// Packet framer: collects the five bytes of a packet, decodes it and runs the LED counter.
module lspd_framer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [lspd_pkg::BYTE_W-1:0]  rx_byte,
	input  logic [lspd_pkg::LED_W-1:0]   led_period,
	output logic                         push,
	output lspd_pkg::res_t               res
);

	// Byte position within the packet.
	localparam logic [2:0] POS_CMD    = 3'd0;
	localparam logic [2:0] POS_DX     = 3'd1;
	localparam logic [2:0] POS_DY     = 3'd2;
	localparam logic [2:0] POS_DXY    = 3'd3;
	localparam logic [2:0] POS_COLOR  = 3'd4;

	logic [2:0]                  pos_q;
	logic [lspd_pkg::BYTE_W-1:0] cmd_q;
	logic [lspd_pkg::BYTE_W-1:0] first_q;
	logic [lspd_pkg::BYTE_W-1:0] second_q;
	logic [lspd_pkg::BYTE_W-1:0] low_q;
	logic [lspd_pkg::LED_W-1:0]  led_cnt_q;
	logic                        led_q;
	logic                        is_point;
	logic [lspd_pkg::LED_W-1:0]  led_cnt_next;
	logic                        led_next;

	// Byte position sequencing; a sync byte in the command slot is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_CMD;
		end else if (accept) begin
			unique case (pos_q)
				POS_CMD: begin
					if (rx_byte != lspd_pkg::SYNC_BYTE) begin
						pos_q <= POS_DX;
					end
				end
				POS_DX:    pos_q <= POS_DY;
				POS_DY:    pos_q <= POS_DXY;
				POS_DXY:   pos_q <= POS_COLOR;
				default:   pos_q <= POS_CMD;
			endcase
		end
	end

	// Packet byte capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_q == POS_CMD) begin
				cmd_q <= rx_byte;
			end
			if (pos_q == POS_DX) begin
				first_q <= rx_byte;
			end
			if (pos_q == POS_DY) begin
				second_q <= rx_byte;
			end
			if (pos_q == POS_DXY) begin
				low_q <= rx_byte;
			end
		end
	end

	assign push = accept && (pos_q == POS_COLOR);

	// Command decode of the finished packet, with the color byte taken live.
	always_comb begin
		res          = '0;
		is_point     = 1'b0;
		unique case (cmd_q[7:4])
			lspd_pkg::CMD_POINT: begin
				is_point        = 1'b1;
				res.event_res   = lspd_pkg::EV_POINT;
				res.dac_a_word  = {lspd_pkg::DAC_A_PREFIX, second_q, low_q[7:4]};
				res.dac_b_word  = {lspd_pkg::DAC_B_PREFIX, first_q, low_q[3:0]};
				res.red_level   = rx_byte[7:5];
				res.green_level = rx_byte[3:1];
				res.blue_level  = cmd_q[3:1];
			end
			lspd_pkg::CMD_SET_RATE: begin
				res.event_res  = lspd_pkg::EV_SET_RATE;
				res.point_rate = {first_q, second_q};
			end
			lspd_pkg::CMD_RESET:    res.event_res = lspd_pkg::EV_RESET;
			lspd_pkg::CMD_IDENTIFY: res.event_res = lspd_pkg::EV_IDENTIFY;
			default:                res.event_res = lspd_pkg::EV_UNKNOWN;
		endcase

		// Status LED countdown advances on every point.
		led_cnt_next = led_cnt_q;
		led_next     = led_q;
		if (is_point) begin
			if (led_cnt_q == '0) begin
				led_cnt_next = led_period;
				led_next     = ~led_q;
			end else begin
				led_cnt_next = led_cnt_q - 1'b1;
			end
		end
		res.status_led = led_next;
	end

	// LED counter and level update when a packet completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_cnt_q <= lspd_pkg::LED_PERIOD_RST;
			led_q     <= 1'b1;
		end else if (push) begin
			led_cnt_q <= led_cnt_next;
			led_q     <= led_next;
		end
	end

endmodule

// ===== rtl/core/lspd_out_buf.sv =====
// Two-entry result buffer: an output register backed by a skid register.
module lspd_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lspd_pkg::res_t res,
	output logic           in_ready,
	lspd_res_if.source     res_out
);

	logic           main_valid_q;
	logic           skid_valid_q;
	lspd_pkg::res_t main_q;
	lspd_pkg::res_t skid_q;
	logic           pop;

	assign pop      = main_valid_q && res_out.ready;
	assign in_ready = !skid_valid_q;

	// Occupancy of the two entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	// Payload movement: the skid word moves forward before new words enter.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= res;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= res;
			end else begin
				main_q <= res;
			end
		end
	end

	assign res_out.valid       = main_valid_q;
	assign res_out.event_res   = main_q.event_res;
	assign res_out.dac_a_word  = main_q.dac_a_word;
	assign res_out.dac_b_word  = main_q.dac_b_word;
	assign res_out.red_level   = main_q.red_level;
	assign res_out.green_level = main_q.green_level;
	assign res_out.blue_level  = main_q.blue_level;
	assign res_out.point_rate  = main_q.point_rate;
	assign res_out.status_led  = main_q.status_led;

endmodule

// ===== rtl/core/laser_serial_packet_decoder_unit.sv =====
// Top level of the laser serial packet decoder.
// The decoder takes one received serial byte per word on rx and frames five-byte packets
// (command, dx, dy, dxy, color); a 0xFF byte where a command is expected is dropped as sync.
// Every fifth byte of a packet produces one result word on res: point commands give the
// two DAC words, color levels and the updated status LED, set-rate commands give the point
// rate, reset, identify and unknown commands give an event code, and every word carries
// the status LED. A byte is accepted every cycle while rx.ready is high; the two-entry
// result buffer lets the decoder keep taking bytes while one result waits, and rx.ready
// drops only while two results are held. The LED period register sits at byte address 0
// of the APB port and takes effect at the next LED reload.
module laser_serial_packet_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lspd_pkg::PADDR_W-1:0]  paddr,
	input  logic [lspd_pkg::PDATA_W-1:0]  pwdata,
	output logic [lspd_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	lspd_byte_if.sink                     rx,
	lspd_res_if.source                    res
);

	logic [lspd_pkg::LED_W-1:0] led_period;
	logic                       accept;
	logic                       push;
	logic                       in_ready;
	lspd_pkg::res_t             dec_res;

	assign rx.ready = in_ready;
	assign accept   = rx.valid && in_ready;

	lspd_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.led_period (led_period)
	);

	lspd_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx.rx_byte),
		.led_period (led_period),
		.push       (push),
		.res        (dec_res)
	);

	lspd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res      (dec_res),
		.in_ready (in_ready),
		.res_out  (res)
	);

endmodule

// ===== test/tb_laser_serial_packet_decoder_unit.sv =====
// Testbench for the laser serial packet decoder: random framed bytes checked against a predictor.
module tb_laser_serial_packet_decoder_unit;

	// Byte positions within one five-byte packet.
	typedef enum logic [2:0] {
		AT_COMMAND,
		AT_DX,
		AT_DY,
		AT_DXY,
		AT_COLOR
	} frame_pos_t;

	// Register addresses: led_period, and one unused slot whose writes must be dropped.
	localparam logic [lspd_pkg::PADDR_W-1:0] LED_PERIOD_ADDR = {lspd_pkg::REG_LED_PERIOD, 2'b00};
	localparam logic [lspd_pkg::PADDR_W-1:0] UNUSED_REG_ADDR = 3'd4;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [lspd_pkg::PADDR_W-1:0] paddr;
	logic [lspd_pkg::PDATA_W-1:0] pwdata;
	logic [lspd_pkg::PDATA_W-1:0] prdata;
	logic pready;

	lspd_byte_if rx_if();
	lspd_res_if res_if();

	laser_serial_packet_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.rx(rx_if),
		.res(res_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bytes waiting to be sent and decoded results still to arrive.
	logic [lspd_pkg::BYTE_W-1:0] rx_bytes_pending[$];
	lspd_pkg::res_t expected_results[$];
	lspd_pkg::res_t oldest_result;

	int unsigned tx_idle_pct;
	int unsigned rx_stall_pct;
	int unsigned fail_count;

	// Predictor copy of the decoder state and its period register.
	frame_pos_t frame_pos = AT_COMMAND;
	logic [lspd_pkg::BYTE_W-1:0] pkt_command = '0;
	logic [lspd_pkg::BYTE_W-1:0] pkt_dx = '0;
	logic [lspd_pkg::BYTE_W-1:0] pkt_dy = '0;
	logic [lspd_pkg::BYTE_W-1:0] pkt_dxy = '0;
	logic [lspd_pkg::LED_W-1:0] led_countdown = lspd_pkg::LED_PERIOD_RST;
	logic [lspd_pkg::LED_W-1:0] led_period_reg = lspd_pkg::LED_PERIOD_RST;
	logic led_on = 1'b1;

	// Advances the framing state by one received byte and queues the decoded packet.
	task automatic frame_rx_byte(input logic [lspd_pkg::BYTE_W-1:0] b);
		lspd_pkg::res_t r;
		r = '0;
		case (frame_pos)
			AT_COMMAND: begin
				if (b != lspd_pkg::SYNC_BYTE) begin
					pkt_command = b;
					frame_pos = AT_DX;
				end
			end
			AT_DX: begin
				pkt_dx = b;
				frame_pos = AT_DY;
			end
			AT_DY: begin
				pkt_dy = b;
				frame_pos = AT_DXY;
			end
			AT_DXY: begin
				pkt_dxy = b;
				frame_pos = AT_COLOR;
			end
			default: begin
				frame_pos = AT_COMMAND;
				case (pkt_command[7:4])
					lspd_pkg::CMD_POINT: begin
						r.event_res = lspd_pkg::EV_POINT;
						r.dac_a_word = {lspd_pkg::DAC_A_PREFIX, pkt_dy, pkt_dxy[7:4]};
						r.dac_b_word = {lspd_pkg::DAC_B_PREFIX, pkt_dx, pkt_dxy[3:0]};
						r.red_level = b[7:5];
						r.green_level = b[3:1];
						r.blue_level = pkt_command[3:1];
						// The LED toggles when the countdown has run out.
						if (led_countdown == '0) begin
							led_countdown = led_period_reg;
							led_on = ~led_on;
						end else begin
							led_countdown = led_countdown - 1'b1;
						end
					end
					lspd_pkg::CMD_SET_RATE: begin
						r.event_res = lspd_pkg::EV_SET_RATE;
						r.point_rate = {pkt_dx, pkt_dy};
					end
					lspd_pkg::CMD_RESET: r.event_res = lspd_pkg::EV_RESET;
					lspd_pkg::CMD_IDENTIFY: r.event_res = lspd_pkg::EV_IDENTIFY;
					default: r.event_res = lspd_pkg::EV_UNKNOWN;
				endcase
				r.status_led = led_on;
				expected_results.push_back(r);
			end
		endcase
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Byte driver: a new word is offered once the previous one has been taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
			rx_if.rx_byte <= '0;
		end else if (!rx_if.valid || rx_if.ready) begin
			if (rx_if.valid)
				frame_rx_byte(rx_if.rx_byte);
			if (rx_bytes_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				rx_if.valid <= 1'b1;
				rx_if.rx_byte <= rx_bytes_pending.pop_front();
			end else begin
				rx_if.valid <= 1'b0;
			end
		end
	end

	// Result monitor: each accepted word is checked against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
			if (res_if.valid && res_if.ready) begin
				if (expected_results.size() == 0) begin
					$error("result word with no expectation, event_res 0x%0h", res_if.event_res);
					fail_count++;
				end else begin
					oldest_result = expected_results.pop_front();
					check_field("event_res", oldest_result.event_res, res_if.event_res);
					check_field("dac_a_word", oldest_result.dac_a_word, res_if.dac_a_word);
					check_field("dac_b_word", oldest_result.dac_b_word, res_if.dac_b_word);
					check_field("red_level", oldest_result.red_level, res_if.red_level);
					check_field("green_level", oldest_result.green_level, res_if.green_level);
					check_field("blue_level", oldest_result.blue_level, res_if.blue_level);
					check_field("point_rate", oldest_result.point_rate, res_if.point_rate);
					check_field("status_led", oldest_result.status_led, res_if.status_led);
				end
			end
		end
	end

	// Register write over the APB port; the predictor copy follows only the exact led_period address.
	task automatic apb_write(input logic [lspd_pkg::PADDR_W-1:0] addr,
		input logic [lspd_pkg::PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == LED_PERIOD_ADDR)
			led_period_reg = data[lspd_pkg::LED_W-1:0];
	endtask

	// Waits until every byte is taken and every result has come back.
	task automatic wait_idle();
		while (rx_bytes_pending.size() != 0 || rx_if.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_packet(input logic [lspd_pkg::BYTE_W-1:0] command,
		input logic [lspd_pkg::BYTE_W-1:0] dx, input logic [lspd_pkg::BYTE_W-1:0] dy,
		input logic [lspd_pkg::BYTE_W-1:0] dxy, input logic [lspd_pkg::BYTE_W-1:0] color);
		rx_bytes_pending.push_back(command);
		rx_bytes_pending.push_back(dx);
		rx_bytes_pending.push_back(dy);
		rx_bytes_pending.push_back(dxy);
		rx_bytes_pending.push_back(color);
	endtask

	task automatic queue_point();
		queue_packet({lspd_pkg::CMD_POINT, 4'($urandom_range(15))}, 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom));
	endtask

	// Mostly well-formed packets of every kind, with sync bytes and stray bytes mixed in.
	task automatic queue_random_bytes(input int unsigned count);
		int unsigned pick;
		logic [3:0] nib;
		logic [lspd_pkg::BYTE_W-1:0] command;
		int unsigned start;
		start = rx_bytes_pending.size();
		while (rx_bytes_pending.size() - start < count) begin
			pick = $urandom_range(99);
			nib = 4'($urandom_range(15));
			if (pick < 8) begin
				repeat ($urandom_range(1, 3)) rx_bytes_pending.push_back(8'($urandom));
				continue;
			end
			if (pick < 16)
				rx_bytes_pending.push_back(lspd_pkg::SYNC_BYTE);
			pick = $urandom_range(99);
			if (pick < 45)
				command = {lspd_pkg::CMD_POINT, nib};
			else if (pick < 60)
				command = {lspd_pkg::CMD_SET_RATE, nib};
			else if (pick < 70)
				command = {lspd_pkg::CMD_RESET, nib};
			else if (pick < 80)
				command = {lspd_pkg::CMD_IDENTIFY, nib};
			else
				command = 8'($urandom);
			queue_packet(command, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		int unsigned waited;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		res_if.ready = 1'b0;
		fail_count = 0;
		tx_idle_pct = 22;
		rx_stall_pct = 71;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Shortest period; the running countdown keeps its reset value until it reloads.
		apb_write(LED_PERIOD_ADDR, {16'($urandom), 16'd0});

		// Directed packets: sync byte, extreme point, each command, and 0xFF as data.
		rx_bytes_pending.push_back(lspd_pkg::SYNC_BYTE);
		queue_packet({lspd_pkg::CMD_POINT, 4'hE}, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		queue_packet({lspd_pkg::CMD_SET_RATE, 4'hF}, 8'hFF, 8'h00, 8'h5A, 8'h00);
		queue_packet({lspd_pkg::CMD_RESET, 4'h0}, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		queue_packet({lspd_pkg::CMD_IDENTIFY, 4'h7}, 8'h00, 8'hFF, 8'h00, 8'hFF);
		queue_packet(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		queue_random_bytes(110);
		wait_idle();

		// Receiver busy side swapped, longest period.
		tx_idle_pct = 71;
		rx_stall_pct = 22;
		apb_write(LED_PERIOD_ADDR, {16'($urandom), 16'hFFFF});
		queue_random_bytes(110);
		wait_idle();

		// Full rate: a run of back-to-back points under a short period, then mixed packets.
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		apb_write(LED_PERIOD_ADDR, {16'($urandom), 16'd2});
		repeat (20) queue_point();
		queue_random_bytes(40);
		wait_idle();

		// Period zero, and a write to the unused slot, which changes nothing.
		apb_write(LED_PERIOD_ADDR, 32'd0);
		apb_write(UNUSED_REG_ADDR, 32'hFFFF_FFFF);
		repeat (10) queue_point();
		queue_random_bytes(30);
		wait_idle();

		// Longest period again, then a last run of points and mixed packets.
		apb_write(LED_PERIOD_ADDR, 32'h0000_FFFF);
		repeat (5) queue_point();
		queue_random_bytes(30);

		while (rx_bytes_pending.size() != 0 || rx_if.valid)
			@(negedge clk);
		waited = 0;
		while (expected_results.size() != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("laser_serial_packet_decoder_unit test passed");
		end else begin
			$display("laser_serial_packet_decoder_unit test failed");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#400000;
		$display("laser_serial_packet_decoder_unit test failed");
		$finish;
	end

endmodule
